// ===== sv/lcbc_pkg.sv =====
// Shared types and constants for the Luhn card brand checker.
package lcbc_pkg;

    localparam int CARD_W        = 63;
    localparam int BIN_W         = 64;
    localparam int BITS_PER_STEP = 8;
    localparam int CONVERT_STEPS = BIN_W / BITS_PER_STEP;
    localparam int BCD_DIGITS    = 20;
    localparam int BCD_W         = BCD_DIGITS * 4;
    localparam int SCAN_STEPS    = BCD_DIGITS / 2;
    localparam int STEP_W        = $clog2(SCAN_STEPS);
    localparam int COUNT_W       = 5;
    localparam int CLASS_W       = 2;
    localparam int MAX_DIGITS    = 19;

    localparam logic [CLASS_W-1:0] CLASS_INVALID    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_AMEX       = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_MASTERCARD = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_VISA       = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              load;
        logic              convert;
        logic              scan;
        logic              finish;
        logic [STEP_W-1:0] pair;
    } t_cmd;

endpackage

// ===== sv/luhn_card_brand_check.sv =====
// Luhn mod-10 card checker: takes one card number, reports checksum, length and
// brand. A word is accepted when start is high and busy is low; its result
// appears on the result ports for one cycle with o_valid high, and the receiver
// cannot stall it. The work runs as binary-to-decimal conversion (one byte of
// the number per cycle), digit scanning (two decimal digits per cycle), a
// classification step and the step in which the result is presented.
// busy drops in the cycle in which o_valid rises, so the next word may be taken
// then; a word is not taken while the last one is still in work. Numbers of
// more than 19 digits or equal to zero report checksum_ok low and class
// invalid.
module luhn_card_brand_check
    import lcbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CARD_W-1:0]  i_card_number,
    output logic               o_valid,
    output logic [CLASS_W-1:0] o_card_class,
    output logic               o_checksum_ok,
    output logic [COUNT_W-1:0] o_digit_count
);

    t_cmd cmd;

    lcbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    lcbc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_card_number (i_card_number),
        .o_card_class  (o_card_class),
        .o_checksum_ok (o_checksum_ok),
        .o_digit_count (o_digit_count)
    );

endmodule

// ===== sv/lcbc_datapath.sv =====
// Datapath: binary to BCD conversion, Luhn digit scan and brand classification.
module lcbc_datapath
    import lcbc_pkg::*;
(
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [CARD_W-1:0]  i_card_number,
    output logic [CLASS_W-1:0] o_card_class,
    output logic               o_checksum_ok,
    output logic [COUNT_W-1:0] o_digit_count
);

    logic [BIN_W-1:0]   r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [3:0]         r_sum;
    logic [3:0]         r_top;
    logic [3:0]         r_next;
    logic [3:0]         r_prev_hi;
    logic [COUNT_W-1:0] r_count;
    logic [CLASS_W-1:0] r_class;
    logic               r_ok;
    logic [COUNT_W-1:0] r_count_out;

    logic [BCD_W-1:0]   n_bcd;
    logic [3:0]         n_sum;
    logic [3:0]         d0;
    logic [3:0]         d1;
    logic [3:0]         d1_dbl;
    logic [4:0]         pair_sum;
    logic [6:0]         lead2;
    logic               ok;
    logic [CLASS_W-1:0] n_class;

    // Shift-and-add-three conversion, one byte of the binary value per cycle.
    always_comb begin
        logic [BCD_W-1:0] v;
        v = r_bcd;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int j = 0; j < BCD_DIGITS; j++) begin
                if (v[j*4 +: 4] >= 4'd5) begin
                    v[j*4 +: 4] = v[j*4 +: 4] + 4'd3;
                end
            end
            v = {v[BCD_W-2:0], r_bin[BIN_W-1-b]};
        end
        n_bcd = v;
    end

    // The low digit of a pair sits in an odd position from the right and is
    // added as it is; the high digit is doubled with its digits summed.
    always_comb begin
        logic [4:0] s;
        d0       = r_bcd[3:0];
        d1       = r_bcd[7:4];
        d1_dbl   = (d1 > 4'd4) ? 4'({d1, 1'b0} - 5'd9) : 4'({d1, 1'b0});
        pair_sum = 5'(d0) + 5'(d1_dbl);
        s        = 5'(r_sum) + pair_sum;
        if (s >= 5'd20) begin
            n_sum = 4'(s - 5'd20);
        end else if (s >= 5'd10) begin
            n_sum = 4'(s - 5'd10);
        end else begin
            n_sum = 4'(s);
        end
    end

    always_comb begin
        lead2 = (r_count >= 5'd2) ? (7'({r_top, 3'b000}) + 7'({r_top, 1'b0}) + 7'(r_next))
                                  : 7'(r_top);
        ok = (r_count != '0) && (r_count <= COUNT_W'(MAX_DIGITS)) && (r_sum == 4'd0);
        n_class = CLASS_INVALID;
        if (ok) begin
            if ((r_count == 5'd15) && ((lead2 == 7'd34) || (lead2 == 7'd37))) begin
                n_class = CLASS_AMEX;
            end else if ((r_count == 5'd16) && (lead2 >= 7'd51) && (lead2 <= 7'd55)) begin
                n_class = CLASS_MASTERCARD;
            end else if ((r_top == 4'd4) && ((r_count == 5'd13) || (r_count == 5'd16))) begin
                n_class = CLASS_VISA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= {1'b0, i_card_number};
            r_bcd     <= '0;
            r_sum     <= '0;
            r_top     <= '0;
            r_next    <= '0;
            r_prev_hi <= '0;
            r_count   <= '0;
        end else if (i_cmd.convert) begin
            r_bin <= {r_bin[BIN_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            r_bcd <= n_bcd;
        end else if (i_cmd.scan) begin
            r_bcd     <= {8'd0, r_bcd[BCD_W-1:8]};
            r_sum     <= n_sum;
            r_prev_hi <= d1;
            // The highest nonzero digit seen so far fixes length and prefix.
            if (d1 != 4'd0) begin
                r_count <= {i_cmd.pair, 1'b0} + 5'd2;
                r_top   <= d1;
                r_next  <= d0;
            end else if (d0 != 4'd0) begin
                r_count <= {i_cmd.pair, 1'b0} + 5'd1;
                r_top   <= d0;
                r_next  <= r_prev_hi;
            end
        end
        if (i_cmd.finish) begin
            r_class     <= n_class;
            r_ok        <= ok;
            r_count_out <= r_count;
        end
    end

    assign o_card_class  = r_class;
    assign o_checksum_ok = r_ok;
    assign o_digit_count = r_count_out;

endmodule

// ===== sv/lcbc_ctrl.sv =====
// Controller: sequences conversion, digit scan and result strobe.
module lcbc_ctrl
    import lcbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_valid;
    logic              n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_valid       = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.convert = 1'b0;
        o_cmd.scan    = 1'b0;
        o_cmd.finish  = 1'b0;
        o_cmd.pair    = r_step;
        busy          = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_cmd.convert = 1'b1;
                if (r_step == STEP_W'(CONVERT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_step == STEP_W'(SCAN_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_FINISH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_valid      = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid = r_valid;

endmodule
